// ===== hw/rtl/svp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the stack with value purge.
// Used by the controller, the datapath, the top level and the checker.
package svp_pkg;

    localparam int DEPTH  = 128;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int OCNT_W = 8;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_PURGE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_PURGE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic push;
        logic pop_issue;
        logic pop_empty;
        logic pop_finish;
        logic purge_init;
        logic purge_step;
        logic purge_finish;
        logic nop;
    } t_dp_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] cmd;
        logic       empty;
        logic       purge_done;
    } t_dp_stat;

endpackage

// ===== hw/rtl/svp_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine for the stack with value purge.
// Depends on svp_pkg for the state, command and handshake struct types.
module svp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  svp_pkg::t_dp_stat i_stat,
    output logic              busy,
    output svp_pkg::t_dp_ctl  o_ctl
);
    import svp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        busy    = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_ctl.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_stat.cmd)
                    CMD_PUSH: begin
                        o_ctl.push = 1'b1;
                        n_state    = S_IDLE;
                    end
                    CMD_POP: begin
                        if (i_stat.empty) begin
                            o_ctl.pop_empty = 1'b1;
                            n_state         = S_IDLE;
                        end else begin
                            o_ctl.pop_issue = 1'b1;
                            n_state         = S_POP_WAIT;
                        end
                    end
                    CMD_PURGE: begin
                        o_ctl.purge_init = 1'b1;
                        n_state          = S_PURGE;
                    end
                    default: begin
                        o_ctl.nop = 1'b1;
                        n_state   = S_IDLE;
                    end
                endcase
            end
            S_POP_WAIT: begin
                o_ctl.pop_finish = 1'b1;
                n_state          = S_IDLE;
            end
            S_PURGE: begin
                if (i_stat.purge_done) begin
                    o_ctl.purge_finish = 1'b1;
                    n_state            = S_IDLE;
                end else begin
                    o_ctl.purge_step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/svp_dpath.sv =====
`timescale 1ns / 1ps
// Datapath for the stack with value purge: word store, entry count,
// purge pointers and the result register. Depends on svp_pkg.
module svp_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [1:0]                  i_command,
    input  logic signed [31:0]          i_value,
    input  svp_pkg::t_dp_ctl            i_ctl,
    output svp_pkg::t_dp_stat           o_stat,
    output logic                        o_valid,
    output logic signed [31:0]          o_data,
    output logic [1:0]                  o_status,
    output logic [7:0]                  o_count
);
    import svp_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];

    logic [1:0]         r_cmd,   n_cmd;
    logic [WORD_W-1:0]  r_value, n_value;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_rd,    n_rd;
    logic [CNT_W-1:0]   r_wr,    n_wr;
    logic [CNT_W-1:0]   r_n,     n_n;
    logic               r_rv,    n_rv;
    logic [WORD_W-1:0]  r_rdata;

    logic               r_valid;
    logic [WORD_W-1:0]  r_res_data;
    logic [1:0]         r_res_status;
    logic [OCNT_W-1:0]  r_res_count;

    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [WORD_W-1:0]  wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
    logic [CNT_W-1:0]   cnt_dec;
    logic               res_load;
    logic [WORD_W-1:0]  res_data;
    t_status            res_status;

    assign cnt_dec = r_count - 1'b1;

    always_comb begin
        n_cmd      = r_cmd;
        n_value    = r_value;
        n_count    = r_count;
        n_rd       = r_rd;
        n_wr       = r_wr;
        n_n        = r_n;
        n_rv       = r_rv;
        we         = 1'b0;
        waddr      = '0;
        wdata      = r_value;
        re         = 1'b0;
        raddr      = '0;
        res_load   = 1'b0;
        res_data   = '0;
        res_status = ST_OK;

        if (i_ctl.accept) begin
            n_cmd   = i_command;
            n_value = $unsigned(i_value);
        end
        if (i_ctl.push) begin
            res_load = 1'b1;
            if (r_count == CNT_W'(DEPTH)) begin
                res_status = ST_FULL;
            end else begin
                we      = 1'b1;
                waddr   = r_count[ADDR_W-1:0];
                n_count = r_count + 1'b1;
            end
        end
        if (i_ctl.pop_issue) begin
            re      = 1'b1;
            raddr   = cnt_dec[ADDR_W-1:0];
            n_count = cnt_dec;
        end
        if (i_ctl.pop_empty) begin
            res_load   = 1'b1;
            res_data   = '1;
            res_status = ST_EMPTY;
        end
        if (i_ctl.pop_finish) begin
            res_load = 1'b1;
            res_data = r_rdata;
        end
        if (i_ctl.purge_init) begin
            n_rd = '0;
            n_wr = '0;
            n_n  = r_count;
            n_rv = 1'b0;
        end
        if (i_ctl.purge_step) begin
            // Reads run one entry ahead of the compare; the write pointer
            // never passes the entry being read, so the compaction is safe.
            if (r_rd != r_n) begin
                re    = 1'b1;
                raddr = r_rd[ADDR_W-1:0];
                n_rd  = r_rd + 1'b1;
                n_rv  = 1'b1;
            end else begin
                n_rv = 1'b0;
            end
            if (r_rv && (r_rdata != r_value)) begin
                we    = 1'b1;
                waddr = r_wr[ADDR_W-1:0];
                wdata = r_rdata;
                n_wr  = r_wr + 1'b1;
            end
        end
        if (i_ctl.purge_finish) begin
            res_load = 1'b1;
            n_count  = r_wr;
        end
        if (i_ctl.nop) begin
            res_load = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rv    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_rv    <= n_rv;
            r_valid <= res_load;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_value <= n_value;
        r_rd    <= n_rd;
        r_wr    <= n_wr;
        r_n     <= n_n;
        if (res_load) begin
            r_res_data   <= res_data;
            r_res_status <= res_status;
            r_res_count  <= OCNT_W'(n_count);
        end
    end

    assign o_stat.cmd        = r_cmd;
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.purge_done = (r_rd == r_n) && !r_rv;

    assign o_valid  = r_valid;
    assign o_data   = $signed(r_res_data);
    assign o_status = r_res_status;
    assign o_count  = r_res_count;

endmodule

// ===== hw/rtl/stack_with_value_purge.sv =====
`timescale 1ns / 1ps
// Top level of the stack with value purge.
// Joins svp_ctrl and svp_dpath; depends on svp_pkg.
//
// Usage:
// A request is taken at a rising edge where start is high and busy is low.
// It carries i_command (0 push, 1 pop, 2 purge) and the signed word i_value.
// Every request gives exactly one result: o_valid is high for one cycle with
// o_data (popped word, -1 on an empty pop, 0 otherwise), o_status (0 ok,
// 1 full on push, 2 empty on pop) and o_count, the entry count after the
// request. The receiver cannot stall; the result is simply presented once.
// Busy stays high while a request is in work and drops in the cycle the
// result is shown, so the next request can be taken alongside that result.
// Between acceptance and the result strobe, which also sets the spacing of
// back-to-back requests: push and the unused command pass the execute step,
// pop adds one registered read of the word store, and purge walks the held
// entries, reading one entry per step and writing each kept one back down
// while the next is read, with a final step to compare the last entry read;
// on an empty stack the walk ends at once.
// Reset (synchronous, active low) empties the stack and returns the
// controller to idle; the word store itself is not cleared, as only
// entries below the count are ever read.
module stack_with_value_purge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_command,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    output logic signed [31:0] o_data,
    output logic [1:0]         o_status,
    output logic [7:0]         o_count
);
    import svp_pkg::*;

    // Command and status groups between the controller and the datapath.
    t_dp_ctl  ctl;
    t_dp_stat stat;

    // The controller sequences each request: one execute step for push,
    // pop or the unused code, a read wait for pop and a walk for purge.
    svp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .busy    (busy),
        .o_ctl   (ctl)
    );

    // The datapath holds the store, the count and the result register.
    svp_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_command (i_command),
        .i_value   (i_value),
        .i_ctl     (ctl),
        .o_stat    (stat),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .o_status  (o_status),
        .o_count   (o_count)
    );

endmodule

// ===== hw/rtl/svp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the stack with value purge, bound to the top level.
// Depends on svp_pkg for status codes and the depth.
module svp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic signed [31:0] o_data,
    input logic [1:0]         o_status,
    input logic [7:0]         o_count
);
    import svp_pkg::*;

    // A taken request leaves the block busy in the cycle after it is taken.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after a request was taken");

    // Results never come in consecutive cycles.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // An empty pop returns -1 with a zero count.
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_EMPTY)) |-> ((o_data == -32'sd1) && (o_count == '0)))
        else $error("empty status with wrong data or count");

    // A full push leaves the stack at its depth and returns zero data.
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> ((o_count == OCNT_W'(DEPTH)) && (o_data == '0)))
        else $error("full status with wrong data or count");

    // A result strobe shows the block free to take the next request, with a defined status code.
    a_free_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && (o_status != 2'd3)))
        else $error("busy or bad status while a result is shown");

endmodule

bind stack_with_value_purge svp_checker u_svp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_data   (o_data),
    .o_status (o_status),
    .o_count  (o_count)
);

// ===== sim/stack_with_value_purge_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for stack_with_value_purge: push, pop and purge requests
// are checked against a behavioral stack image kept in the bench.
// Depends on svp_pkg and the stack_with_value_purge RTL.
module stack_with_value_purge_tb;

    import svp_pkg::*;

    // Command code outside the defined set; the block must treat it as a no-op.
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         STALL_LIMIT  = 1000;

    typedef struct {
        logic signed [31:0] data;
        t_status            status;
        logic [7:0]         count;
    } t_stack_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_command;
    logic signed [31:0] i_value;
    logic               o_valid;
    logic signed [31:0] o_data;
    logic [1:0]         o_status;
    logic [7:0]         o_count;

    // Bench copy of the stack contents, updated when a request is accepted.
    logic signed [31:0] stack_image [DEPTH];
    int                 image_count = 0;
    t_stack_result      expected_results [$];
    int                 mismatch_count = 0;
    int                 stall_cycles = 0;

    stack_with_value_purge u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_command (i_command),
        .i_value   (i_value),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .o_status  (o_status),
        .o_count   (o_count)
    );

    always #5 i_clk = ~i_clk;

    // Applies one request to the stack image and returns the result it must produce.
    function automatic t_stack_result apply_to_stack_image(input logic [1:0] cmd,
                                                           input logic signed [31:0] word);
        t_stack_result r;
        int            kept;
        r.data   = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_PUSH: begin
                if (image_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    stack_image[image_count] = word;
                    image_count++;
                end
            end
            CMD_POP: begin
                if (image_count == 0) begin
                    r.data   = -32'sd1;
                    r.status = ST_EMPTY;
                end else begin
                    image_count--;
                    r.data = stack_image[image_count];
                end
            end
            CMD_PURGE: begin
                // Compact the survivors downward, keeping bottom-to-top order.
                kept = 0;
                for (int i = 0; i < image_count; i++) begin
                    if (stack_image[i] != word) begin
                        stack_image[kept] = stack_image[i];
                        kept++;
                    end
                end
                image_count = kept;
            end
            default: begin
            end
        endcase
        r.count = image_count[7:0];
        return r;
    endfunction

    // Words come often from a small pool so that purges find repeated matches.
    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'sd0;
            1: return 32'sd1;
            2: return -32'sd1;
            3: return 32'h8000_0000;
            4: return 32'h7fff_ffff;
            5: return 32'sd42;
            default: return $urandom();
        endcase
    endfunction

    // Purge targets are mostly words actually held, so purges remove entries.
    function automatic logic signed [31:0] pick_purge_word();
        if (image_count > 0 && $urandom_range(0, 9) < 7) begin
            return stack_image[$urandom_range(0, image_count - 1)];
        end
        return pick_word();
    endfunction

    function automatic logic [1:0] pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return CMD_PUSH;
        if (r < 75) return CMD_POP;
        if (r < 97) return CMD_PURGE;
        return CMD_UNUSED;
    endfunction

    function automatic int pick_gap(input bit no_idle);
        return no_idle ? 0 : $urandom_range(0, 12);
    endfunction

    // Sends one request. It is entered in the time step of a rising edge and returns
    // in the step of the edge that accepted the request, leaving start high so a
    // following request with no gap goes out back to back.
    task automatic send_request(input logic [1:0] cmd, input logic signed [31:0] word,
                                input int gap);
        if (gap > 0) begin
            // Junk on the payload while start is low must be ignored.
            start     <= 1'b0;
            i_command <= 2'($urandom());
            i_value   <= $urandom();
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_command <= cmd;
        i_value   <= word;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_results.push_back(apply_to_stack_image(cmd, word));
    endtask

    // Holds off new requests until every expected result has been seen.
    task automatic drain_results();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic test_empty_stack();
        send_request(CMD_POP, 32'sd0, 0);
        send_request(CMD_POP, -32'sd1, 1);
        send_request(CMD_PURGE, 32'sd0, 0);
        send_request(CMD_UNUSED, 32'sd5, 2);
        drain_results();
    endtask

    task automatic test_word_extremes();
        send_request(CMD_PUSH, 32'h8000_0000, 0);
        send_request(CMD_PUSH, 32'h7fff_ffff, 0);
        send_request(CMD_PUSH, -32'sd1, 3);
        send_request(CMD_PUSH, 32'sd0, 0);
        send_request(CMD_PUSH, 32'h5555_aaaa, 1);
        send_request(CMD_UNUSED, 32'sd0, 0);
        repeat (5) send_request(CMD_POP, $urandom(), 0);
        send_request(CMD_POP, 32'sd0, 0);
        drain_results();
    endtask

    task automatic test_purge_order();
        send_request(CMD_PUSH, 32'sd5, 0);
        send_request(CMD_PUSH, 32'sd9, 0);
        send_request(CMD_PUSH, 32'sd5, 0);
        send_request(CMD_PUSH, 32'sd7, 0);
        send_request(CMD_PUSH, 32'sd5, 0);
        send_request(CMD_PURGE, 32'sd5, 0);
        // A purge that matches nothing must leave the stack alone.
        send_request(CMD_PURGE, 32'sd3, 4);
        repeat (3) send_request(CMD_POP, 32'sd0, 0);
        drain_results();
    endtask

    // Mixed traffic; idle and back-to-back stretches are picked at random, and the sender
    // stops now and then until the block has caught up completely.
    task automatic test_random_mix(input int n_requests);
        bit no_idle;
        logic [1:0] cmd;
        no_idle = 1'b0;
        for (int k = 0; k < n_requests; k++) begin
            if (k % 50 == 0) no_idle = $urandom_range(0, 1);
            if (k % 100 == 99) drain_results();
            cmd = pick_command();
            send_request(cmd, (cmd == CMD_PURGE) ? pick_purge_word() : pick_word(),
                         pick_gap(no_idle));
        end
        drain_results();
    endtask

    // Fills the stack to the top, overflows it, purges at full depth and unwinds.
    task automatic test_full_stack(input int rounds);
        bit no_idle;
        for (int r = 0; r < rounds; r++) begin
            no_idle = r[0];
            while (image_count < DEPTH) send_request(CMD_PUSH, pick_word(), pick_gap(no_idle));
            repeat ($urandom_range(1, 3)) send_request(CMD_PUSH, pick_word(), pick_gap(no_idle));
            send_request(CMD_PURGE, $urandom(), pick_gap(no_idle));
            repeat ($urandom_range(2, 4)) begin
                send_request(CMD_PURGE, pick_purge_word(), pick_gap(no_idle));
            end
            repeat ($urandom_range(5, 20)) send_request(CMD_POP, $urandom(), pick_gap(no_idle));
        end
        while (image_count > 0) send_request(CMD_POP, $urandom(), pick_gap(1'b0));
        send_request(CMD_POP, $urandom(), 0);
        drain_results();
    endtask

    task automatic report_mismatch(input string field, input longint want, input longint got);
        mismatch_count++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    // Each result strobe is matched against the oldest outstanding expectation.
    always @(posedge i_clk) begin : check_results
        t_stack_result want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: result with no request outstanding, actual data %0d",
                         $time, o_data);
            end else begin
                want = expected_results.pop_front();
                if (o_data !== want.data) report_mismatch("data", want.data, o_data);
                if (o_status !== want.status) report_mismatch("status", want.status, o_status);
                if (o_count !== want.count) report_mismatch("count", want.count, o_count);
            end
        end
    end

    // Ends the run if neither a request nor a result moves for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        start     <= 1'b0;
        i_command <= CMD_PUSH;
        i_value   <= '0;
        i_rst_n   <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_empty_stack();
        test_word_extremes();
        test_purge_order();
        test_random_mix(700);
        test_full_stack(4);
        test_random_mix(570);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
